FILE: rtl/pcd_pkg.sv
`timescale 1ns / 1ps

package pcd_pkg;

    localparam int unsigned POS_W         = 16;
    localparam int unsigned CAP_W         = 17;
    localparam int unsigned MAX_INPUT_LEN = 65535;
    localparam int unsigned QUEUE_DEPTH   = 4;

    localparam logic [CAP_W-1:0] CAP_RESET = 17'h10000;
    localparam logic [7:0]       PCT_CHAR  = 8'h25;

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_TRUNC    = 2'd1;
    localparam logic [1:0] ST_BAD_HEX  = 2'd2;
    localparam logic [1:0] ST_TOO_LONG = 2'd3;

    typedef enum logic [2:0] {
        PH_NORMAL = 3'b001,
        PH_PCT    = 3'b010,
        PH_DIGIT  = 3'b100
    } phase_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_byte;
    } src_beat_t;

    typedef struct packed {
        logic             item_kind;
        logic [7:0]       data_byte;
        logic [POS_W-1:0] out_position;
        logic             fits_capacity;
        logic [1:0]       status_code;
        logic [POS_W-1:0] decoded_length;
        logic             end_flag;
    } dst_beat_t;

    // one queued unit of work: an optional data beat and an optional status beat
    typedef struct packed {
        logic             has_data;
        logic [7:0]       data;
        logic [POS_W-1:0] pos;
        logic             has_status;
        logic [1:0]       code;
        logic [POS_W-1:0] length;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

    // {valid, value}
    function automatic logic [4:0] hex_digit(input logic [7:0] ch);
        logic [4:0] r;
        r = 5'd0;
        if (ch >= 8'h30 && ch <= 8'h39)
            r = {1'b1, ch[3:0]};
        else if ((ch >= 8'h41 && ch <= 8'h46) || (ch >= 8'h61 && ch <= 8'h66))
            r = {1'b1, ch[3:0] + 4'd9};
        return r;
    endfunction

endpackage

FILE: rtl/percent_decoder.sv
`timescale 1ns / 1ps

// channel   dir  handshake              payload
// src       in   src_valid / src_stall  src_beat  (in_byte, last_byte)
// dst       out  dst_valid / dst_stall  dst_beat  (data or end-of-message status)
// cfg       in   cfg_we                 cfg_data  (output_capacity)
//
// One source beat per cycle while src_stall is low. A beat is decoded in the cycle
// it is taken and reaches dst through a QUEUE_DEPTH entry queue, then the output
// register, which sends one beat per cycle while dst_stall is low; a last byte
// yielding both a data beat and a status beat sends two; the queue absorbs that.
// Reset clears the decode state, queue and output; capacity resets to 65536.
// src_stall is high only while the queue is full.

module percent_decoder #(
    parameter int unsigned MAX_INPUT_LEN = pcd_pkg::MAX_INPUT_LEN,
    parameter int unsigned QUEUE_DEPTH   = pcd_pkg::QUEUE_DEPTH
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      src_valid,
    output logic                      src_stall,
    input  pcd_pkg::src_beat_t        src_beat,
    output logic                      dst_valid,
    input  logic                      dst_stall,
    output pcd_pkg::dst_beat_t        dst_beat,
    input  logic                      cfg_we,
    input  logic [pcd_pkg::CAP_W-1:0] cfg_data
);

    logic            push, pop;
    pcd_pkg::entry_t push_entry, head_entry;
    pcd_pkg::qstat_t qstat;

    pcd_front #(
        .MAX_INPUT_LEN (MAX_INPUT_LEN)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .src_valid  (src_valid),
        .src_stall  (src_stall),
        .src_beat   (src_beat),
        .qstat      (qstat),
        .push       (push),
        .push_entry (push_entry)
    );

    pcd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head_entry (head_entry),
        .qstat      (qstat)
    );

    pcd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .head_entry (head_entry),
        .qstat      (qstat),
        .pop        (pop),
        .dst_valid  (dst_valid),
        .dst_stall  (dst_stall),
        .dst_beat   (dst_beat)
    );

`ifndef SYNTHESIS
    // a data beat that is not final is always followed by its status beat
    a_status_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (dst_valid && !dst_stall && dst_beat.item_kind == pcd_pkg::KIND_DATA
            && !dst_beat.end_flag)
        |=> (dst_valid && dst_beat.item_kind == pcd_pkg::KIND_STATUS))
        else $error("status beat missing after non-final data beat");

    a_status_final: assert property (@(posedge clk) disable iff (!rst_n)
        (dst_valid && dst_beat.item_kind == pcd_pkg::KIND_STATUS) |-> dst_beat.end_flag)
        else $error("status beat without end flag");

    a_err_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (dst_valid && dst_beat.item_kind == pcd_pkg::KIND_STATUS
            && dst_beat.status_code != pcd_pkg::ST_OK)
        |-> (dst_beat.decoded_length == '0))
        else $error("nonzero length on error status");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !qstat.full)
        else $error("queue push while full");
`endif

endmodule

FILE: rtl/pcd_front.sv
`timescale 1ns / 1ps

module pcd_front #(
    parameter int unsigned MAX_INPUT_LEN = pcd_pkg::MAX_INPUT_LEN
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               src_valid,
    output logic               src_stall,
    input  pcd_pkg::src_beat_t src_beat,
    input  pcd_pkg::qstat_t    qstat,
    output logic               push,
    output pcd_pkg::entry_t    push_entry
);

    localparam int unsigned CNT_W = $clog2(MAX_INPUT_LEN + 2);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_INPUT_LEN);
    localparam logic [pcd_pkg::POS_W-1:0] POS_SAT = '1;

    pcd_pkg::phase_t             phase_reg, phase_next;
    logic [3:0]                  hi_reg, hi_next;
    logic [CNT_W-1:0]            icnt_reg, icnt_next;
    logic [pcd_pkg::POS_W-1:0]   ocnt_reg, ocnt_next;
    logic [1:0]                  err_reg, err_next;

    logic                        fire;
    logic                        have_data;
    logic [7:0]                  value;
    logic [4:0]                  dig;
    logic [CNT_W-1:0]            icnt_inc;
    logic [pcd_pkg::POS_W-1:0]   ocnt_inc;
    logic [1:0]                  code;

    assign src_stall = qstat.full;
    assign fire      = src_valid && !qstat.full;
    assign dig       = pcd_pkg::hex_digit(src_beat.in_byte);

    always_comb
    begin
        phase_next = phase_reg;
        hi_next    = hi_reg;
        err_next   = err_reg;
        have_data  = 1'b0;
        value      = 8'h00;
        icnt_inc   = (icnt_reg <= CNT_MAX) ? icnt_reg + CNT_W'(1) : icnt_reg;

        if (err_reg == pcd_pkg::ST_OK)
        begin
            case (phase_reg)
                pcd_pkg::PH_NORMAL:
                begin
                    if (src_beat.in_byte == pcd_pkg::PCT_CHAR)
                    begin
                        if (src_beat.last_byte)
                            err_next = pcd_pkg::ST_TRUNC;
                        else
                            phase_next = pcd_pkg::PH_PCT;
                    end
                    else
                    begin
                        have_data = 1'b1;
                        value     = src_beat.in_byte;
                    end
                end
                pcd_pkg::PH_PCT:
                begin
                    phase_next = pcd_pkg::PH_NORMAL;
                    if (src_beat.last_byte)
                        err_next = pcd_pkg::ST_TRUNC;
                    else if (!dig[4])
                        err_next = pcd_pkg::ST_BAD_HEX;
                    else
                    begin
                        hi_next    = dig[3:0];
                        phase_next = pcd_pkg::PH_DIGIT;
                    end
                end
                pcd_pkg::PH_DIGIT:
                begin
                    phase_next = pcd_pkg::PH_NORMAL;
                    if (!dig[4])
                        err_next = pcd_pkg::ST_BAD_HEX;
                    else
                    begin
                        have_data = 1'b1;
                        value     = {hi_reg, dig[3:0]};
                    end
                end
                default:
                begin
                    phase_next = pcd_pkg::PH_NORMAL;
                end
            endcase
        end

        ocnt_inc = (have_data && ocnt_reg != POS_SAT) ? ocnt_reg + 1'b1 : ocnt_reg;
        code     = (icnt_inc > CNT_MAX) ? pcd_pkg::ST_TOO_LONG : err_next;

        push_entry.has_data   = have_data;
        push_entry.data       = value;
        push_entry.pos        = ocnt_reg;
        push_entry.has_status = src_beat.last_byte;
        push_entry.code       = code;
        push_entry.length     = (code == pcd_pkg::ST_OK) ? ocnt_inc : '0;

        push = fire && (have_data || src_beat.last_byte);

        if (src_beat.last_byte)
        begin
            phase_next = pcd_pkg::PH_NORMAL;
            hi_next    = 4'd0;
            err_next   = pcd_pkg::ST_OK;
            icnt_next  = '0;
            ocnt_next  = '0;
        end
        else
        begin
            icnt_next = icnt_inc;
            ocnt_next = ocnt_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= pcd_pkg::PH_NORMAL;
            hi_reg    <= 4'd0;
            icnt_reg  <= '0;
            ocnt_reg  <= '0;
            err_reg   <= pcd_pkg::ST_OK;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            hi_reg    <= hi_next;
            icnt_reg  <= icnt_next;
            ocnt_reg  <= ocnt_next;
            err_reg   <= err_next;
        end
    end

endmodule

FILE: rtl/pcd_queue.sv
`timescale 1ns / 1ps

module pcd_queue #(
    parameter int unsigned DEPTH = pcd_pkg::QUEUE_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  pcd_pkg::entry_t push_entry,
    input  logic            pop,
    output pcd_pkg::entry_t head_entry,
    output pcd_pkg::qstat_t qstat
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    pcd_pkg::entry_t  mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign qstat.full  = (cnt_reg == CNT_FULL);
    assign qstat.empty = (cnt_reg == '0);
    assign do_push     = push && !qstat.full;
    assign do_pop      = pop && !qstat.empty;
    assign head_entry  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

FILE: rtl/pcd_back.sv
`timescale 1ns / 1ps

module pcd_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [pcd_pkg::CAP_W-1:0]   cfg_data,
    input  pcd_pkg::entry_t             head_entry,
    input  pcd_pkg::qstat_t             qstat,
    output logic                        pop,
    output logic                        dst_valid,
    input  logic                        dst_stall,
    output pcd_pkg::dst_beat_t          dst_beat
);

    logic [pcd_pkg::CAP_W-1:0]  cap_reg;
    logic                       valid_reg, valid_next;
    pcd_pkg::dst_beat_t         beat_reg, beat_next;
    logic                       pend_reg, pend_next;
    logic [1:0]                 pend_code_reg, pend_code_next;
    logic [pcd_pkg::POS_W-1:0]  pend_len_reg, pend_len_next;
    logic                       can_load;

    assign can_load  = !valid_reg || !dst_stall;
    assign pop       = can_load && !pend_reg && !qstat.empty;
    assign dst_valid = valid_reg;
    assign dst_beat  = beat_reg;

    always_comb
    begin
        valid_next     = valid_reg;
        beat_next      = beat_reg;
        pend_next      = pend_reg;
        pend_code_next = pend_code_reg;
        pend_len_next  = pend_len_reg;

        if (can_load)
        begin
            valid_next = 1'b0;
            if (pend_reg)
            begin
                valid_next               = 1'b1;
                pend_next                = 1'b0;
                beat_next                = '0;
                beat_next.item_kind      = pcd_pkg::KIND_STATUS;
                beat_next.status_code    = pend_code_reg;
                beat_next.decoded_length = pend_len_reg;
                beat_next.end_flag       = 1'b1;
            end
            else if (!qstat.empty)
            begin
                valid_next = 1'b1;
                beat_next  = '0;
                if (head_entry.has_data)
                begin
                    beat_next.item_kind     = pcd_pkg::KIND_DATA;
                    beat_next.data_byte     = head_entry.data;
                    beat_next.out_position  = head_entry.pos;
                    beat_next.fits_capacity =
                        ({1'b0, head_entry.pos} + pcd_pkg::CAP_W'(1)) < cap_reg;
                    beat_next.end_flag      = !head_entry.has_status;
                    pend_next               = head_entry.has_status;
                    pend_code_next          = head_entry.code;
                    pend_len_next           = head_entry.length;
                end
                else
                begin
                    beat_next.item_kind      = pcd_pkg::KIND_STATUS;
                    beat_next.status_code    = head_entry.code;
                    beat_next.decoded_length = head_entry.length;
                    beat_next.end_flag       = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        beat_reg      <= beat_next;
        pend_code_reg <= pend_code_next;
        pend_len_reg  <= pend_len_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg   <= pcd_pkg::CAP_RESET;
            valid_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                cap_reg <= cfg_data;
            valid_reg <= valid_next;
            pend_reg  <= pend_next;
        end
    end

endmodule

FILE: tb/tb_percent_decoder.sv
`timescale 1ns / 1ps

module tb_percent_decoder;

    typedef enum logic [1:0] {
        SCAN_PLAIN,
        SCAN_AFTER_PCT,
        SCAN_AFTER_HIGH
    } scan_state_t;

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      src_valid = 1'b0;
    logic                      src_stall;
    pcd_pkg::src_beat_t        src_beat  = '0;
    logic                      dst_valid;
    logic                      dst_stall = 1'b0;
    pcd_pkg::dst_beat_t        dst_beat;
    logic                      cfg_we    = 1'b0;
    logic [pcd_pkg::CAP_W-1:0] cfg_data  = '0;

    // decoder state as the block should hold it
    scan_state_t               scan_state = SCAN_PLAIN;
    logic [3:0]                high_digit = 4'd0;
    logic [pcd_pkg::CAP_W-1:0] chars_seen = '0;
    logic [pcd_pkg::POS_W-1:0] bytes_out  = '0;
    logic [1:0]                msg_error  = pcd_pkg::ST_OK;
    logic [pcd_pkg::CAP_W-1:0] capacity   = pcd_pkg::CAP_RESET;

    pcd_pkg::src_beat_t encoded_backlog[$];
    pcd_pkg::dst_beat_t decoded_due[$];

    int   mismatches = 0;
    logic src_fired  = 1'b0;
    int   send_wait  = 0;
    int   send_calm  = 0;
    int   stall_left = 0;
    int   stall_len  = 0;

    percent_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_beat  (src_beat),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .dst_beat  (dst_beat),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [7:0] d;
        d = 8'd0;
        if (c >= 8'h30 && c <= 8'h39)
            return {1'b1, 4'(c - 8'h30)};
        if (c >= 8'h41 && c <= 8'h46)
            d = c - 8'h37;
        else if (c >= 8'h61 && c <= 8'h66)
            d = c - 8'h57;
        else
            return 5'd0;
        return {1'b1, d[3:0]};
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic decode_char(input pcd_pkg::src_beat_t b);
        pcd_pkg::dst_beat_t r;
        logic [4:0]         dig;
        logic               emit;
        logic [7:0]         val;
        logic [1:0]         code;
        emit = 1'b0;
        val  = 8'd0;
        dig  = hex_value(b.in_byte);
        if (chars_seen <= pcd_pkg::MAX_INPUT_LEN)
            chars_seen = chars_seen + 1'b1;
        if (msg_error == pcd_pkg::ST_OK)
        begin
            case (scan_state)
                SCAN_PLAIN:
                begin
                    if (b.in_byte == pcd_pkg::PCT_CHAR)
                    begin
                        if (b.last_byte)
                            msg_error = pcd_pkg::ST_TRUNC;
                        else
                            scan_state = SCAN_AFTER_PCT;
                    end
                    else
                    begin
                        emit = 1'b1;
                        val  = b.in_byte;
                    end
                end
                SCAN_AFTER_PCT:
                begin
                    if (b.last_byte)
                    begin
                        msg_error  = pcd_pkg::ST_TRUNC;
                        scan_state = SCAN_PLAIN;
                    end
                    else if (!dig[4])
                    begin
                        msg_error  = pcd_pkg::ST_BAD_HEX;
                        scan_state = SCAN_PLAIN;
                    end
                    else
                    begin
                        high_digit = dig[3:0];
                        scan_state = SCAN_AFTER_HIGH;
                    end
                end
                default:
                begin
                    scan_state = SCAN_PLAIN;
                    if (!dig[4])
                        msg_error = pcd_pkg::ST_BAD_HEX;
                    else
                    begin
                        emit = 1'b1;
                        val  = {high_digit, dig[3:0]};
                    end
                end
            endcase
        end
        if (emit)
        begin
            r               = '0;
            r.item_kind     = pcd_pkg::KIND_DATA;
            r.data_byte     = val;
            r.out_position  = bytes_out;
            r.fits_capacity = (32'(bytes_out) + 1 < 32'(capacity));
            r.end_flag      = !b.last_byte;
            decoded_due.push_back(r);
            if (bytes_out != 16'hFFFF)
                bytes_out = bytes_out + 1'b1;
        end
        if (b.last_byte)
        begin
            code = msg_error;
            if (chars_seen > pcd_pkg::MAX_INPUT_LEN)
                code = pcd_pkg::ST_TOO_LONG;
            r                = '0;
            r.item_kind      = pcd_pkg::KIND_STATUS;
            r.status_code    = code;
            r.decoded_length = (code == pcd_pkg::ST_OK) ? bytes_out : '0;
            r.end_flag       = 1'b1;
            decoded_due.push_back(r);
            scan_state = SCAN_PLAIN;
            high_digit = 4'd0;
            chars_seen = '0;
            bytes_out  = '0;
            msg_error  = pcd_pkg::ST_OK;
        end
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_beat(input pcd_pkg::dst_beat_t got);
        pcd_pkg::dst_beat_t want;
        if (decoded_due.size() == 0)
        begin
            $display("%0t: beat expected none, got %h", $time, got);
            mismatches++;
            return;
        end
        want = decoded_due.pop_front();
        compare_field("item_kind", 32'(want.item_kind), 32'(got.item_kind));
        compare_field("data_byte", 32'(want.data_byte), 32'(got.data_byte));
        compare_field("out_position", 32'(want.out_position), 32'(got.out_position));
        compare_field("fits_capacity", 32'(want.fits_capacity), 32'(got.fits_capacity));
        compare_field("status_code", 32'(want.status_code), 32'(got.status_code));
        compare_field("decoded_length", 32'(want.decoded_length),
                      32'(got.decoded_length));
        compare_field("end_flag", 32'(want.end_flag), 32'(got.end_flag));
    endtask

    always @(posedge clk)
    begin
        src_fired <= src_valid && !src_stall;
        if (rst_n)
        begin
            if (cfg_we)
                capacity = cfg_data;
            if (dst_valid && !dst_stall)
                check_beat(dst_beat);
            if (src_valid && !src_stall)
                decode_char(src_beat);
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            src_valid <= 1'b0;
        else if (!src_valid || src_fired)
        begin
            if (send_wait != 0)
            begin
                send_wait <= send_wait - 1;
                src_valid <= 1'b0;
            end
            else if (encoded_backlog.size() != 0)
            begin
                src_beat  <= encoded_backlog.pop_front();
                src_valid <= 1'b1;
                if (send_calm != 0)
                    send_calm = send_calm - 1;
                else
                begin
                    send_wait <= idle_len();
                    if ($urandom_range(0, 99) < 3)
                        send_calm = $urandom_range(20, 80);
                end
            end
            else
                src_valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            dst_stall <= 1'b0;
        else if (stall_left != 0)
            stall_left <= stall_left - 1;
        else if (dst_stall)
        begin
            dst_stall <= 1'b0;
            if ($urandom_range(0, 99) < 3)
                stall_left <= $urandom_range(30, 100);
            else
                stall_left <= $urandom_range(0, 6);
        end
        else
        begin
            stall_len = idle_len();
            if (stall_len != 0)
            begin
                dst_stall  <= 1'b1;
                stall_left <= stall_len - 1;
            end
        end
    end

    task automatic push_char(input logic [7:0] c, input logic last);
        pcd_pkg::src_beat_t b;
        b.in_byte   = c;
        b.last_byte = last;
        encoded_backlog.push_back(b);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 10)
            return 8'h30 + {4'd0, v};
        if ($urandom_range(0, 1) != 0)
            return 8'h61 + {4'd0, v} - 8'd10;
        return 8'h41 + {4'd0, v} - 8'd10;
    endfunction

    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (c == pcd_pkg::PCT_CHAR);
        return c;
    endfunction

    function automatic logic [7:0] bad_char();
        logic [7:0] c;
        logic [4:0] h;
        do
        begin
            c = 8'($urandom_range(0, 255));
            h = hex_value(c);
        end
        while (h[4]);
        return c;
    endfunction

    task automatic random_message(inout int queued);
        logic [7:0] msg[$];
        int         parts;
        int         flaw;
        parts = $urandom_range(1, 10);
        flaw  = $urandom_range(0, 99);
        repeat (parts)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                msg.push_back(pcd_pkg::PCT_CHAR);
                msg.push_back(hex_char(4'($urandom_range(0, 15))));
                msg.push_back(hex_char(4'($urandom_range(0, 15))));
            end
            else
                msg.push_back(plain_char());
        end
        if (flaw < 6)
            msg.push_back(pcd_pkg::PCT_CHAR);
        else if (flaw < 12)
        begin
            msg.push_back(pcd_pkg::PCT_CHAR);
            msg.push_back(hex_char(4'($urandom_range(0, 15))));
        end
        else if (flaw < 24)
        begin
            msg.push_back(pcd_pkg::PCT_CHAR);
            if (flaw >= 18)
                msg.push_back(hex_char(4'($urandom_range(0, 15))));
            msg.push_back(bad_char());
            repeat ($urandom_range(0, 4))
                msg.push_back(8'($urandom_range(0, 255)));
        end
        else if (flaw < 30)
        begin
            msg.delete();
            repeat ($urandom_range(1, 8))
                msg.push_back(($urandom_range(0, 3) == 0) ? pcd_pkg::PCT_CHAR
                                                          : 8'($urandom_range(0, 255)));
        end
        foreach (msg[i])
            push_char(msg[i], i == msg.size() - 1);
        queued += msg.size();
    endtask

    task automatic drain();
        while (encoded_backlog.size() != 0 || src_valid || decoded_due.size() != 0)
            @(posedge clk);
        repeat (pcd_pkg::QUEUE_DEPTH + 6) @(posedge clk);
    endtask

    task automatic set_capacity(input logic [pcd_pkg::CAP_W-1:0] value);
        drain();
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(negedge clk);
        cfg_we   <= 1'b0;
    endtask

    initial
    begin
        #20_000_000;
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        logic [pcd_pkg::CAP_W-1:0] caps[$];
        int                        queued;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed, at reset capacity
        push_char(8'h00, 1'b1);
        push_char(8'hFF, 1'b0);
        push_char(pcd_pkg::PCT_CHAR, 1'b0); push_char("0", 1'b0); push_char("0", 1'b0);
        push_char(pcd_pkg::PCT_CHAR, 1'b0); push_char("f", 1'b0); push_char("F", 1'b0);
        push_char(pcd_pkg::PCT_CHAR, 1'b0); push_char("9", 1'b0); push_char("a", 1'b0);
        push_char(pcd_pkg::PCT_CHAR, 1'b0); push_char("4", 1'b0); push_char("1", 1'b1);
        push_char(pcd_pkg::PCT_CHAR, 1'b1);
        push_char("x", 1'b0); push_char(pcd_pkg::PCT_CHAR, 1'b0); push_char("4", 1'b1);
        push_char(pcd_pkg::PCT_CHAR, 1'b0); push_char("G", 1'b1);
        push_char(pcd_pkg::PCT_CHAR, 1'b0); push_char("z", 1'b0); push_char("A", 1'b1);
        push_char(pcd_pkg::PCT_CHAR, 1'b0); push_char("4", 1'b0); push_char("g", 1'b1);

        caps = '{17'd0, 17'd1, 17'd2, 17'd7, 17'h1FFFF, 17'd65535, 17'd0,
                 pcd_pkg::CAP_RESET};
        caps[6] = 17'($urandom_range(3, 16));
        foreach (caps[i])
        begin
            set_capacity(caps[i]);
            queued = 0;
            while (queued < 80)
                random_message(queued);
        end

        drain();
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
